// ===== sv/xtl_pkg.sv =====
// Package for the markup start tag lexer: item types, character codes and lexer phases.
package xtl_pkg;

    // Field widths fixed by the item formats
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned OFS_W  = 12;

    // Characters the lexer reacts to
    localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;  // '<'
    localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;  // '>'
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;  // '/'
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;  // '='
    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;  // '"'

    // Record kinds
    localparam logic [1:0] KIND_ATTR = 2'd0;
    localparam logic [1:0] KIND_TEXT = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    // Syntax error codes
    localparam logic [2:0] ERR_NO_LT       = 3'd0;
    localparam logic [2:0] ERR_EARLY_END   = 3'd1;
    localparam logic [2:0] ERR_BAD_SLASH   = 3'd2;
    localparam logic [2:0] ERR_NAME_ALPHA  = 3'd3;
    localparam logic [2:0] ERR_NO_EQ       = 3'd4;
    localparam logic [2:0] ERR_NO_OPEN_Q   = 3'd5;
    localparam logic [2:0] ERR_NO_CLOSE_Q  = 3'd6;
    localparam logic [2:0] ERR_TEXT_UNTERM = 3'd7;

    // Lexer phases
    typedef enum logic [3:0] {
        PH_LEAD   = 4'd0,
        PH_TAG    = 4'd1,
        PH_GAP    = 4'd2,
        PH_SLASH  = 4'd3,
        PH_NAME   = 4'd4,
        PH_EQ     = 4'd5,
        PH_VFIRST = 4'd6,
        PH_VAL    = 4'd7,
        PH_TEXT   = 4'd8,
        PH_DONE   = 4'd9
    } xtl_phase_t;

    // Input item
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              line_last;
    } xtl_in_t;

    // Result item
    typedef struct packed {
        logic [1:0]       record_kind;
        logic [2:0]       error_code;
        logic [OFS_W-1:0] name_offset;
        logic [OFS_W-1:0] name_length;
        logic [OFS_W-1:0] value_offset;
        logic [OFS_W-1:0] value_length;
        logic             record_last;
    } xtl_out_t;

    // Results of one lexer step: up to two items
    typedef struct packed {
        logic [1:0] count;
        xtl_out_t   rec0;
        xtl_out_t   rec1;
    } xtl_step_t;

    // Build a result item with record_last clear
    function automatic xtl_out_t mk_rec(input logic [1:0] kind, input logic [2:0] err,
                                        input logic [OFS_W-1:0] no,
                                        input logic [OFS_W-1:0] nl,
                                        input logic [OFS_W-1:0] vo,
                                        input logic [OFS_W-1:0] vl);
        xtl_out_t r;
        r.record_kind  = kind;
        r.error_code   = err;
        r.name_offset  = no;
        r.name_length  = nl;
        r.value_offset = vo;
        r.value_length = vl;
        r.record_last  = 1'b0;
        return r;
    endfunction

endpackage

// ===== sv/xtl_lexer_core.sv =====
// Lexer state registers and the per-byte next-state and record logic.
module xtl_lexer_core #(
    parameter int unsigned MAX_LINE_LEN = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  xtl_pkg::xtl_in_t  in_item,
    output xtl_pkg::xtl_step_t step_out
);
    import xtl_pkg::*;

    localparam int unsigned CW = $clog2(MAX_LINE_LEN);
    localparam logic [CW-1:0] LAST_POS = CW'(MAX_LINE_LEN - 1);

    xtl_phase_t phase_reg, phase_next;
    logic       held_reg, held_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] nstart_reg, nstart_next;
    logic [CW-1:0] ncount_reg, ncount_next;
    logic [CW-1:0] vstart_reg, vstart_next;
    logic [CW-1:0] vcount_reg, vcount_next;

    logic [CHAR_W-1:0] c;
    logic [CW-1:0]     pos_inc;
    logic              gap_go;
    logic              text_done;
    logic [2:0]        end_code;
    logic [1:0]        cnt;
    xtl_out_t          rec0, rec1;

    function automatic logic [CW-1:0] wrap_inc(input logic [CW-1:0] v);
        return (v == LAST_POS) ? '0 : v + CW'(1);
    endfunction

    function automatic logic is_ws(input logic [CHAR_W-1:0] ch);
        return (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);
    endfunction

    function automatic logic is_alpha(input logic [CHAR_W-1:0] ch);
        return (ch >= 8'd65 && ch <= 8'd90) || (ch >= 8'd97 && ch <= 8'd122);
    endfunction

    function automatic logic is_namech(input logic [CHAR_W-1:0] ch);
        return is_alpha(ch) || (ch >= 8'd48 && ch <= 8'd57) || (ch == 8'd45);
    endfunction

    // State registers, advanced once per processed byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_LEAD;
            held_reg   <= 1'b0;
            pos_reg    <= '0;
            nstart_reg <= '0;
            ncount_reg <= '0;
            vstart_reg <= '0;
            vcount_reg <= '0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            held_reg   <= held_next;
            pos_reg    <= pos_next;
            nstart_reg <= nstart_next;
            ncount_reg <= ncount_next;
            vstart_reg <= vstart_next;
            vcount_reg <= vcount_next;
        end
    end

    // One lexer step: next state and up to two records
    always_comb begin
        c           = in_item.char_code;
        pos_inc     = wrap_inc(pos_reg);
        phase_next  = phase_reg;
        held_next   = held_reg;
        nstart_next = nstart_reg;
        ncount_next = ncount_reg;
        vstart_next = vstart_reg;
        vcount_next = vcount_reg;
        pos_next    = pos_inc;
        gap_go      = 1'b0;
        text_done   = 1'b0;
        end_code    = ERR_EARLY_END;
        cnt         = 2'd0;
        rec0        = '0;
        rec1        = '0;

        unique case (phase_reg)
            PH_LEAD: begin
                if (c == CH_LT) begin
                    phase_next = PH_TAG;
                end else if (!is_ws(c)) begin
                    rec0 = mk_rec(KIND_ERR, ERR_NO_LT, '0, '0, '0, '0);
                    cnt = 2'd1;
                    phase_next = PH_DONE;
                end
            end
            PH_TAG: begin
                if (!is_alpha(c)) begin
                    gap_go = 1'b1;
                end
            end
            PH_GAP: begin
                gap_go = 1'b1;
            end
            PH_SLASH: begin
                if (c == CH_GT) begin
                    rec0 = mk_rec(KIND_END, ERR_NO_LT, '0, '0, '0, '0);
                end else begin
                    rec0 = mk_rec(KIND_ERR, ERR_BAD_SLASH, '0, '0, '0, '0);
                end
                cnt = 2'd1;
                phase_next = PH_DONE;
            end
            PH_NAME: begin
                if (is_namech(c)) begin
                    ncount_next = wrap_inc(ncount_reg);
                end else if (c == CH_EQ) begin
                    phase_next = PH_EQ;
                end else begin
                    rec0 = mk_rec(KIND_ERR, ERR_NO_EQ, '0, '0, '0, '0);
                    cnt = 2'd1;
                    phase_next = PH_DONE;
                end
            end
            PH_EQ: begin
                if (c == CH_QUOTE) begin
                    vstart_next = pos_inc;
                    phase_next  = PH_VFIRST;
                end else begin
                    rec0 = mk_rec(KIND_ERR, ERR_NO_OPEN_Q, '0, '0, '0, '0);
                    cnt = 2'd1;
                    phase_next = PH_DONE;
                end
            end
            PH_VFIRST, PH_VAL: begin
                if (c == CH_QUOTE) begin
                    // an empty value is reported with length zero
                    if (phase_reg == PH_VFIRST) begin
                        vcount_next = '0;
                    end
                    rec0 = mk_rec(KIND_ATTR, ERR_NO_LT, OFS_W'(nstart_reg),
                                  OFS_W'(ncount_reg), OFS_W'(vstart_reg),
                                  OFS_W'(vcount_next));
                    cnt = 2'd1;
                    phase_next = PH_GAP;
                end else begin
                    vcount_next = (phase_reg == PH_VFIRST) ? CW'(1) : wrap_inc(vcount_reg);
                    phase_next  = PH_VAL;
                end
            end
            PH_TEXT: begin
                // a held '<' either closes the body with '/' or counts as text
                if (held_reg) begin
                    held_next = 1'b0;
                    if (c == CH_SLASH) begin
                        rec0 = mk_rec(KIND_TEXT, ERR_NO_LT, OFS_W'(vstart_reg), '0,
                                      OFS_W'(vstart_reg), OFS_W'(vcount_reg));
                        rec1 = mk_rec(KIND_END, ERR_NO_LT, '0, '0, '0, '0);
                        cnt = 2'd2;
                        phase_next = PH_DONE;
                        text_done = 1'b1;
                    end else begin
                        vcount_next = wrap_inc(vcount_reg);
                    end
                end
                if (!text_done) begin
                    if (c == CH_LT) begin
                        held_next = 1'b1;
                    end else begin
                        vcount_next = wrap_inc(vcount_next);
                    end
                end
            end
            default: begin
            end
        endcase

        // Between attributes
        if (gap_go) begin
            if (held_reg) begin
                held_next = 1'b0;
                if (c == CH_SLASH) begin
                    rec0 = mk_rec(KIND_END, ERR_NO_LT, '0, '0, '0, '0);
                end else begin
                    rec0 = mk_rec(KIND_ERR, ERR_NAME_ALPHA, '0, '0, '0, '0);
                end
                cnt = 2'd1;
                phase_next = PH_DONE;
            end else if (is_ws(c)) begin
                phase_next = PH_GAP;
            end else if (c == CH_GT) begin
                vstart_next = pos_inc;
                vcount_next = '0;
                phase_next  = PH_TEXT;
            end else if (c == CH_LT) begin
                held_next  = 1'b1;
                phase_next = PH_GAP;
            end else if (c == CH_SLASH) begin
                phase_next = PH_SLASH;
            end else if (is_alpha(c)) begin
                nstart_next = pos_reg;
                ncount_next = CW'(1);
                phase_next  = PH_NAME;
            end else begin
                rec0 = mk_rec(KIND_ERR, ERR_NAME_ALPHA, '0, '0, '0, '0);
                cnt = 2'd1;
                phase_next = PH_DONE;
            end
        end

        // End of line: report an unfinished statement, then restart
        if (in_item.line_last) begin
            unique case (phase_next)
                PH_LEAD:           end_code = ERR_NO_LT;
                PH_GAP:            end_code = held_next ? ERR_NAME_ALPHA : ERR_EARLY_END;
                PH_SLASH:          end_code = ERR_BAD_SLASH;
                PH_NAME:           end_code = ERR_NO_EQ;
                PH_EQ:             end_code = ERR_NO_OPEN_Q;
                PH_VFIRST, PH_VAL: end_code = ERR_NO_CLOSE_Q;
                PH_TEXT:           end_code = ERR_TEXT_UNTERM;
                default:           end_code = ERR_EARLY_END;
            endcase
            if (phase_next != PH_DONE) begin
                if (cnt == 2'd0) begin
                    rec0 = mk_rec(KIND_ERR, end_code, '0, '0, '0, '0);
                end else begin
                    rec1 = mk_rec(KIND_ERR, end_code, '0, '0, '0, '0);
                end
                cnt = cnt + 2'd1;
            end
            phase_next = PH_LEAD;
            held_next  = 1'b0;
            pos_next   = '0;
        end

        // Flag the final record of this byte
        if (cnt == 2'd1) begin
            rec0.record_last = 1'b1;
        end else if (cnt == 2'd2) begin
            rec1.record_last = 1'b1;
        end

        step_out.count = cnt;
        step_out.rec0  = rec0;
        step_out.rec1  = rec1;
    end

endmodule

// ===== sv/xtl_out_fifo.sv =====
// Four-entry result queue that takes up to two items per cycle and gives one.
module xtl_out_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_en,
    input  xtl_pkg::xtl_step_t  push_data,
    output logic                room2,
    output logic                m_valid,
    input  logic                m_ready,
    output xtl_pkg::xtl_out_t   m_data
);
    import xtl_pkg::*;

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PW    = $clog2(DEPTH);

    xtl_out_t        mem [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [PW:0]     count_reg, count_next;
    logic [1:0]      n_push;
    logic            pop;

    assign n_push  = push_en ? push_data.count : 2'd0;
    assign m_valid = (count_reg != '0);
    assign pop     = m_valid && m_ready;
    assign room2   = (count_reg <= (PW+1)'(DEPTH - 2));
    assign m_data  = mem[rd_reg];

    // Pointer and fill-level update
    always_comb begin
        wr_next    = wr_reg + PW'(n_push);
        rd_next    = pop ? rd_reg + PW'(1) : rd_reg;
        count_next = count_reg + (PW+1)'(n_push) - (PW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    // Storage: the first record at the write pointer, the second after it
    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            mem[wr_reg] <= push_data.rec0;
        end
        if (n_push == 2'd2) begin
            mem[wr_reg + PW'(1)] <= push_data.rec1;
        end
    end

endmodule

// ===== sv/xml_tag_attribute_lexer.sv =====
// Top level of the markup start tag lexer: input register, lexer core and result queue.
//
// Input channel s_*: one byte of a statement line per item, with line_last on the
// final byte. Result channel m_*: attribute, text body, statement end and syntax
// error records; record_last marks the final record caused by one byte.
// Each byte causes zero, one or two records.
// An accepted byte is captured in the input register, lexed when the queue has room
// for two records, and its records are written to the result queue for the receiver.
// Throughput: one byte per cycle while the bytes produce at most one record each and
// the receiver does not stall; the four-entry result queue has a single read port and
// gives one record at a time, so a byte that produces two records slows the input.
// Reset (aresetn low at a clock edge) clears the input register, empties the
// queue and returns the lexer to the start of a line with position zero.
// When the receiver stalls, records collect in the queue; s_ready falls while the
// input register holds a byte and fewer than two queue entries are free, so no
// record is ever dropped.
// Offsets and lengths wrap to zero after MAX_LINE_LEN-1 and carry their low 12 bits.
module xml_tag_attribute_lexer #(
    parameter int unsigned MAX_LINE_LEN = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  xtl_pkg::xtl_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output xtl_pkg::xtl_out_t  m_data
);
    import xtl_pkg::*;

    logic      in_valid_reg, in_valid_next;
    xtl_in_t   in_item_reg;
    logic      room2;
    logic      step_en;
    xtl_step_t step_out;

    // Input register: refilled as soon as its item moves on
    assign step_en = in_valid_reg && room2;
    assign s_ready = !in_valid_reg || room2;

    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step_en) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    xtl_lexer_core #(
        .MAX_LINE_LEN (MAX_LINE_LEN)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (step_en),
        .in_item  (in_item_reg),
        .step_out (step_out)
    );

    xtl_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (step_en),
        .push_data (step_out),
        .room2     (room2),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== sv/xtl_checker.sv =====
// Port-level checker for the markup start tag lexer and its bind to the top level.
module xtl_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input xtl_pkg::xtl_out_t  m_data
);
    import xtl_pkg::*;

    // A stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // End and error records carry no offsets or lengths
    a_no_span: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.record_kind == KIND_END || m_data.record_kind == KIND_ERR) |->
        m_data.name_offset == '0 && m_data.name_length == '0 &&
        m_data.value_offset == '0 && m_data.value_length == '0)
        else $error("end or error record with a span");

    // Only error records carry an error code
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.record_kind != KIND_ERR |-> m_data.error_code == ERR_NO_LT)
        else $error("error code on a non-error record");

    // A text body record has an empty name at the body offset, and a second record follows
    a_text_body: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.record_kind == KIND_TEXT |->
        m_data.name_length == '0 && m_data.name_offset == m_data.value_offset &&
        !m_data.record_last)
        else $error("malformed text body record");

endmodule

bind xml_tag_attribute_lexer xtl_checker u_xtl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
